/* sv/p1305_pkg.sv */
// Shared types and constants for the Poly1305 authenticator.
package p1305_pkg;

    // Accumulator: 17 limbs of 8 bits.
    localparam int LIMBS    = 17;
    localparam int ACC_W    = 8 * LIMBS;
    localparam int KEY_W    = 128;
    // Folded product sum before the partial reduction.
    localparam int PROD_W   = 150;
    // Result of one 8-bit digit times the low part and the folded part.
    localparam int PLO_W    = ACC_W + 8;
    localparam int PUP_W    = KEY_W + 8;
    // Last value of the multiply counter, which counts from zero through the 17 digits
    // of the accumulator and then a drain of the registered products.
    localparam logic [4:0] MUL_LAST = 5'd17;
    localparam logic [4:0] FULL_BLOCK = 5'd16;

    localparam logic [KEY_W-1:0] R_CLAMP = 128'h0ffffffc_0ffffffc_0ffffffc_0fffffff;
    // Adding this constant modulo 2^136 computes h + 5 - 2^130.
    localparam logic [ACC_W-1:0] FIN_ADDEND = {8'd252, 120'd0, 8'd5};

    // Configuration register indexes.
    localparam logic [1:0] CFG_R_LOW  = 2'd0;
    localparam logic [1:0] CFG_R_HIGH = 2'd1;
    localparam logic [1:0] CFG_S_LOW  = 2'd2;
    localparam logic [1:0] CFG_S_HIGH = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_FIN_SEL,
        ST_FIN_ADD
    } state_t;

endpackage

/* sv/poly1305_mac_top.sv */
// Poly1305 one-time authenticator with a byte-serial multiply-reduce datapath.
//
// The key is written through the configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data): index 0 and 1 hold r, 2 and 3 hold s. Writes are taken
// in every cycle and belong only to times when no message block is in flight.
// Message blocks arrive on the data channel; a transaction is taken when
// data_valid is high and data_stall is low. Each block carries up to 16 bytes,
// a byte count and a last flag. The tag leaves on the tag channel, taken when
// tag_valid is high and tag_stall is low.
// A non-empty block passes through the multiplier, which takes one 8-bit digit
// of the accumulator times the whole of r per cycle and then drains its product
// register, and then through the modular reduction before the next
// acceptance. A last block adds the final reduction and the add of s, after
// which the tag is valid; an empty final block goes straight to the final
// reduction.
// The tag sits in an output register, so the next message may start while the
// tag waits. If a new tag is ready while the old one is still stalled, the
// block holds until the old tag has gone.
// Reset clears the key registers, the accumulator and all control state.
module poly1305_mac_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [63:0] data_low,
    input  logic [63:0] data_high,
    input  logic [4:0]  byte_count,
    input  logic        last_block,
    output logic        tag_valid,
    input  logic        tag_stall,
    output logic [63:0] tag_low,
    output logic [63:0] tag_high
);
    import p1305_pkg::*;

    state_t state_reg, state_next;

    logic [63:0]       r_low_reg, r_high_reg, s_low_reg, s_high_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  h_reg, h_next;
    logic [ACC_W-1:0]  lo_reg, lo_next;
    logic [KEY_W-1:0]  up_reg, up_next;
    logic [PLO_W-1:0]  pl_reg, pl_next;
    logic [PUP_W-1:0]  pu_reg, pu_next;
    logic [PROD_W-1:0] p_reg, p_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              last_reg, last_next;
    logic              tag_valid_reg, tag_valid_next;
    logic [KEY_W-1:0]  tag_reg, tag_next;

    logic              accept;
    logic              do_mul;
    logic              do_red;
    logic              do_sel;
    logic              do_fin;

    logic [4:0]        count_clamped;
    logic [KEY_W-1:0]  data_all;
    logic [ACC_W-1:0]  blk;
    logic [ACC_W-1:0]  h_sum;
    logic [ACC_W-1:0]  reduced;
    logic [ACC_W-1:0]  g_val;
    logic [ACC_W-1:0]  with_s;
    logic [22:0]       fold5;

    assign cfg_ready  = 1'b1;
    assign data_stall = (state_reg != ST_IDLE);
    assign tag_valid  = tag_valid_reg;
    assign tag_low    = tag_reg[63:0];
    assign tag_high   = tag_reg[127:64];

    // Padded message block: data bytes below the count, then a single 1 byte.
    always_comb
    begin
        count_clamped = (byte_count > FULL_BLOCK) ? FULL_BLOCK : byte_count;
        data_all = {data_high, data_low};
        blk = '0;
        for (int k = 0; k < LIMBS - 1; k++)
        begin
            if (5'(k) < count_clamped)
            begin
                blk[8*k +: 8] = data_all[8*k +: 8];
            end
            else if (5'(k) == count_clamped)
            begin
                blk[8*k +: 8] = 8'd1;
            end
        end
        if (count_clamped == FULL_BLOCK)
        begin
            blk[ACC_W-1 -: 8] = 8'd1;
        end
        h_sum = acc_reg + blk;
    end

    // Partial reduction: bits above 2^130 fold back with weight 5.
    assign fold5   = {1'b0, p_reg[PROD_W-1:130], 2'b00} + 23'(p_reg[PROD_W-1:130]);
    assign reduced = ACC_W'(p_reg[129:0]) + ACC_W'(fold5);
    assign g_val   = acc_reg + FIN_ADDEND;
    assign with_s  = h_reg + ACC_W'({s_high_reg, s_low_reg});

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (data_valid)
                begin
                    if (count_clamped != 5'd0)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (last_block)
                    begin
                        state_next = ST_FIN_SEL;
                    end
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                state_next = last_reg ? ST_FIN_SEL : ST_IDLE;
            end
            ST_FIN_SEL:
            begin
                state_next = ST_FIN_ADD;
            end
            ST_FIN_ADD:
            begin
                if (!(tag_valid_reg && tag_stall))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the state machine.
    always_comb
    begin
        accept = 1'b0;
        do_mul = 1'b0;
        do_red = 1'b0;
        do_sel = 1'b0;
        do_fin = 1'b0;
        unique case (state_reg)
            ST_IDLE:    accept = data_valid;
            ST_MUL:     do_mul = 1'b1;
            ST_RED:     do_red = 1'b1;
            ST_FIN_SEL: do_sel = 1'b1;
            ST_FIN_ADD: do_fin = !(tag_valid_reg && tag_stall);
            default:    accept = 1'b0;
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        acc_next       = acc_reg;
        h_next         = h_reg;
        lo_next        = lo_reg;
        up_next        = up_reg;
        pl_next        = pl_reg;
        pu_next        = pu_reg;
        p_next         = p_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        tag_next       = tag_reg;
        tag_valid_next = tag_valid_reg && tag_stall;

        if (accept)
        begin
            h_next    = h_sum;
            lo_next   = ACC_W'({r_high_reg, r_low_reg} & R_CLAMP);
            up_next   = '0;
            p_next    = '0;
            cnt_next  = 5'd0;
            last_next = last_block;
        end

        // One digit of h per cycle. lo holds the part of r that lands below
        // 2^136 at this digit position, up the part that wraps with weight 320.
        if (do_mul)
        begin
            pl_next  = PLO_W'(h_reg[7:0]) * PLO_W'(lo_reg);
            pu_next  = PUP_W'(h_reg[7:0]) * PUP_W'(up_reg);
            h_next   = h_reg >> 8;
            lo_next  = lo_reg << 8;
            up_next  = {up_reg[KEY_W-9:0], lo_reg[ACC_W-1 -: 8]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg != 5'd0)
            begin
                p_next = p_reg + PROD_W'(pl_reg) + (PROD_W'(pu_reg) << 8)
                       + (PROD_W'(pu_reg) << 6);
            end
        end

        if (do_red)
        begin
            acc_next = reduced;
        end

        // Keep h + 5 - 2^130 unless it went negative.
        if (do_sel)
        begin
            h_next = g_val[ACC_W-1] ? acc_reg : g_val;
        end

        if (do_fin)
        begin
            tag_next       = with_s[KEY_W-1:0];
            tag_valid_next = 1'b1;
            acc_next       = '0;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_low_reg  <= '0;
            r_high_reg <= '0;
            s_low_reg  <= '0;
            s_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_R_LOW:  r_low_reg  <= cfg_data;
                CFG_R_HIGH: r_high_reg <= cfg_data;
                CFG_S_LOW:  s_low_reg  <= cfg_data;
                CFG_S_HIGH: s_high_reg <= cfg_data;
                default:    r_low_reg  <= r_low_reg;
            endcase
        end
    end

    // Control state and accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            tag_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            tag_valid_reg <= tag_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        lo_reg  <= lo_next;
        up_reg  <= up_next;
        pl_reg  <= pl_next;
        pu_reg  <= pu_next;
        p_reg   <= p_next;
        tag_reg <= tag_next;
    end

endmodule
